### sv/rgb_integral_image_stream_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the integral image stream block
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef RGB_INTEGRAL_IMAGE_STREAM_MACROS_SVH
`define RGB_INTEGRAL_IMAGE_STREAM_MACROS_SVH

// property holds at every edge
`define RGBSAT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define RGBSAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rgbsat_pkg.sv
// ---------------------------------------------------------------------------
// rgbsat_pkg
// Sizes, register indexes and helpers shared by the integral image block.
// ---------------------------------------------------------------------------
package rgbsat_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int NUM_CHAN   = 3;

	localparam int PIX_W   = 8;
	localparam int SAT_W   = 32;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 1;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int LINE_W  = NUM_CHAN * SAT_W;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// last column index of a row for a programmed width, clamped to 1..MAX_WIDTH
	function automatic logic [COL_W-1:0] col_last(input logic [CFG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (32'(v) > MAX_WIDTH)
			r = COL_W'(MAX_WIDTH - 1);
		else
			r = COL_W'(v - CFG_W'(1));
		return r;
	endfunction

	// last row index of a frame for a programmed height, clamped to 1..MAX_HEIGHT
	function automatic logic [ROW_W-1:0] row_last(input logic [CFG_W-1:0] v);
		logic [ROW_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (32'(v) > MAX_HEIGHT)
			r = ROW_W'(MAX_HEIGHT - 1);
		else
			r = ROW_W'(v - CFG_W'(1));
		return r;
	endfunction

endpackage

### sv/rgb_integral_image_stream.sv
// ---------------------------------------------------------------------------
// rgb_integral_image_stream
// Streaming summed-area table for RGB pixels in raster order.
// ---------------------------------------------------------------------------
// Path: stage 1 register (line store read), then output register, to result valid.
// Throughput: one pixel per cycle while the output is not stalled, limited by the single line-store port pair
// (one read issued at accept, one write when the entry is formed).
// Reset: counters and row sums cleared, width 640, height 480; the line store
// is not cleared, row 0 of each frame ignores it, so no clearing pass.
`include "rgb_integral_image_stream_macros.svh"

module rgb_integral_image_stream
	import rgbsat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,

	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,

	output logic             out_valid,
	input  logic             out_ready,
	output logic [SAT_W-1:0] sat_red,
	output logic [SAT_W-1:0] sat_green,
	output logic [SAT_W-1:0] sat_blue,
	output logic             end_of_row,
	output logic             end_of_frame
);

	logic [CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             adv, accept, eor, eof;

	logic             s1_valid_q;
	logic [COL_W-1:0] col_s1;
	logic             row_zero_s1, eor_s1, eof_s1;
	logic [PIX_W-1:0] px_s1 [NUM_CHAN];

	logic             fwd_q;
	logic [LINE_W-1:0] fwd_data_q;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] above_word;
	logic [LINE_W-1:0] line_wdata;
	logic [SAT_W-1:0]  entry [NUM_CHAN];
	logic              lane_step;

	logic             out_valid_q;
	logic [SAT_W-1:0] sat_q [NUM_CHAN];
	logic             eor_q, eof_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// a counter beyond a shrunken size also ends the row or frame
	assign eor = col_q >= col_last(width_q);
	assign eof = eor && (row_q >= row_last(height_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eor) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			row_zero_s1 <= row_q == '0;
			eor_s1      <= eor;
			eof_s1      <= eof;
			px_s1[0]    <= red;
			px_s1[1]    <= green;
			px_s1[2]    <= blue;
			// same column written this cycle: RAM would return stale data
			fwd_q       <= lane_step && (col_s1 == col_q);
			fwd_data_q  <= line_wdata;
		end
	end

	assign lane_step = s1_valid_q && adv;

	rgbsat_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (lane_step),
		.waddr (col_s1),
		.wdata (line_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign above_word = fwd_q ? fwd_data_q : ram_rdata;

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		rgbsat_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (lane_step),
			.clear    (eor_s1),
			.row_zero (row_zero_s1),
			.px       (px_s1[c]),
			.above    (above_word[c*SAT_W +: SAT_W]),
			.entry    (entry[c])
		);
		assign line_wdata[c*SAT_W +: SAT_W] = entry[c];
	end

	// output register merges the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_step) begin
			for (int c = 0; c < NUM_CHAN; c++)
				sat_q[c] <= entry[c];
			eor_q <= eor_s1;
			eof_q <= eof_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign sat_red      = sat_q[0];
	assign sat_green    = sat_q[1];
	assign sat_blue     = sat_q[2];
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

	`RGBSAT_ASSERT_NEXT(a_col_wrap, accept && eor, col_q == '0, "column counter did not wrap")
	`RGBSAT_ASSERT_NEXT(a_out_from_s1, adv && s1_valid_q, out_valid, "stage 1 result lost")
	`RGBSAT_ASSERT(a_eof_in_eor, !(out_valid && end_of_frame) || end_of_row, "frame end off row end")

endmodule

### sv/rgbsat_ram.sv
// ---------------------------------------------------------------------------
// rgbsat_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rgbsat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### sv/rgbsat_lane.sv
// ---------------------------------------------------------------------------
// rgbsat_lane
// One colour channel: running row sum plus the entry from the row above.
// ---------------------------------------------------------------------------
`include "rgb_integral_image_stream_macros.svh"

module rgbsat_lane
	import rgbsat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             clear,
	input  logic             row_zero,
	input  logic [PIX_W-1:0] px,
	input  logic [SAT_W-1:0] above,
	output logic [SAT_W-1:0] entry
);

	logic [SAT_W-1:0] rs_q;
	logic [SAT_W-1:0] rs_next;
	logic [SAT_W-1:0] above_sel;

	assign rs_next   = rs_q + SAT_W'(px);
	// first row of a frame has nothing above it
	assign above_sel = row_zero ? '0 : above;
	assign entry     = rs_next + above_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q <= '0;
		end else if (step) begin
			rs_q <= clear ? '0 : rs_next;
		end
	end

	`RGBSAT_ASSERT_NEXT(a_row_sum_clear, step && clear, rs_q == '0, "row sum not cleared at end of row")

endmodule
